FILE: src/rpn_pkg.sv
// rpn_pkg: shared types, character codes, status codes and tables
// for the rpn expression evaluator; no dependencies
`default_nettype none
package rpn_pkg;

   localparam int STACK_DEPTH     = 16;
   localparam int FRAC_BITS       = 32;
   localparam int MAX_FRAC_DIGITS = 9;
   localparam int ADDR_W          = $clog2(STACK_DEPTH);
   localparam int CNT_W           = $clog2(STACK_DEPTH + 1);
   localparam int QUO_W           = 64 + FRAC_BITS;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DIGIT_LO = 8'd48;
   localparam logic [7:0] CH_DIGIT_HI = 8'd57;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_LEFT  = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_DIVZ  = 3'd4;

   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FIT_LIMIT = 64'd1844674407370955161;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_expression;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [2:0]         status;
   } rsp_type;

   function automatic logic [63:0] pow10(input logic [3:0] n);
      logic [63:0] p;
      case (n)
         4'd0: p = 64'd1;
         4'd1: p = 64'd10;
         4'd2: p = 64'd100;
         4'd3: p = 64'd1000;
         4'd4: p = 64'd10000;
         4'd5: p = 64'd100000;
         4'd6: p = 64'd1000000;
         4'd7: p = 64'd10000000;
         4'd8: p = 64'd100000000;
         4'd9: p = 64'd1000000000;
         4'd10: p = 64'd10000000000;
         4'd11: p = 64'd100000000000;
         4'd12: p = 64'd1000000000000;
         4'd13: p = 64'd10000000000000;
         4'd14: p = 64'd100000000000000;
         default: p = 64'd1000000000000000;
      endcase
      return p;
   endfunction

   function automatic logic [63:0] mag_of(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] limit_of(input logic neg);
      return neg ? SIGN_BIT : MAX_POS;
   endfunction

endpackage
`default_nettype wire

FILE: src/rpn_stack.sv
// rpn_stack: value stack storage, one write and one registered read port
// depends on rpn_pkg
`default_nettype none
module rpn_stack (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic [rpn_pkg::ADDR_W-1:0] waddr,
   input  wire logic [63:0]               wdata,
   input  wire logic [rpn_pkg::ADDR_W-1:0] raddr,
   output logic      [63:0]               rdata
);
   import rpn_pkg::*;

   logic [63:0] mem [STACK_DEPTH];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: src/rpn_div.sv
// rpn_div: iterative restoring divider, (num << FRAC_BITS) / den on magnitudes,
// one quotient bit a cycle, saturated and signed on completion; depends on rpn_pkg
`default_nettype none
module rpn_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   input  wire logic        neg,
   output logic             done,
   output logic [63:0]      value
);
   import rpn_pkg::*;

   localparam int ITER_W = $clog2(QUO_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [64:0]       rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [63:0]       den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [63:0]       value_ff, value_in;
   logic [64:0]       trial;
   logic [63:0]       lim;
   logic [63:0]       mag;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      iter_in  = iter_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      value_in = value_ff;
      trial    = {rem_ff[63:0], quo_ff[QUO_W-1]};
      lim      = limit_of(neg_ff);
      mag      = (quo_ff > {{FRAC_BITS{1'b0}}, lim}) ? lim : quo_ff[63:0];
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         rem_in  = '0;
         quo_in  = {num, {FRAC_BITS{1'b0}}};
         den_in  = den;
         neg_in  = neg;
      end else if (busy_ff) begin
         if (iter_ff == ITER_W'(QUO_W)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = neg_ff ? (64'd0 - mag) : mag;
         end else begin
            iter_in = iter_ff + 1'b1;
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff  <= iter_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule
`default_nettype wire

FILE: src/rpn_mul.sv
// rpn_mul: fixed point multiplier from four 32x32 partial products,
// saturated and signed on completion; depends on rpn_pkg
`default_nettype none
module rpn_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      value
);
   import rpn_pkg::*;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [2:0]   step_ff, step_in;
   logic [63:0]  x_ff, x_in, y_ff, y_in;
   logic         neg_ff, neg_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  value_ff, value_in;
   logic [31:0]  xs, ys;
   logic [63:0]  lim, mag;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      pp_in    = pp_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      value_in = value_ff;
      xs       = step_ff[0] ? x_ff[63:32] : x_ff[31:0];
      ys       = step_ff[1] ? y_ff[63:32] : y_ff[31:0];
      lim      = limit_of(neg_ff);
      mag      = ((acc_ff[127:64+FRAC_BITS] != '0) || (acc_ff[63+FRAC_BITS:FRAC_BITS] > lim))
                 ? lim : acc_ff[63+FRAC_BITS:FRAC_BITS];
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = mag_of(a);
         y_in    = mag_of(b);
         neg_in  = a[63] ^ b[63];
         acc_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff < 3'd4) begin
            pp_in = 64'(xs) * 64'(ys);
            sh_in = 2'(step_ff[0]) + 2'(step_ff[1]);
         end
         if (step_ff != 3'd0 && step_ff < 3'd5) begin
            acc_in = acc_ff + ({64'd0, pp_ff} << (32 * sh_ff));
         end
         if (step_ff == 3'd5) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = neg_ff ? (64'd0 - mag) : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_ff   <= neg_in;
      pp_ff    <= pp_in;
      sh_ff    <= sh_in;
      acc_ff   <= acc_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule
`default_nettype wire

FILE: src/rpn_expression_evaluator.sv
// rpn_expression_evaluator: top level, character sequencer around the stack memory,
// the shared divider and the multiplier; depends on rpn_pkg, rpn_stack, rpn_div, rpn_mul
//
// Usage: one character of an RPN expression per req word (char_code and
// end_of_expression). A word is taken when req_valid is high and req_stall low.
// The block works on one character at a time and holds req_stall high while busy.
// A digit, point or other character passes through S_PRE, S_MAIN and S_NEXT before
// the block returns to S_IDLE and takes the next word. A character that closes a
// number waits for the 96-step restoring divider that scales the digit integer;
// a '/' takes another divider pass, a '*' a pass through the multiplier, and '+'
// and '-' two stack reads, an add or subtract and a write back.
// After the word marked end_of_expression one rsp word comes out with the final
// value and status, then the stack count, error, token and pending-minus state clear.
// The result sits in an output register; while rsp_stall is high it holds and a
// further result waits in S_EMIT with req_stall high, so no new character is taken.
// Reset is synchronous: the stack count, token and error state clear at once;
// the stack memory itself needs no clearing.
`default_nettype none
module rpn_expression_evaluator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rpn_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rpn_pkg::rsp_type      rsp_data
);
   import rpn_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRE   = 4'd1;
   localparam logic [3:0] S_MAIN  = 4'd2;
   localparam logic [3:0] S_NEXT  = 4'd3;
   localparam logic [3:0] S_CLOSE = 4'd4;
   localparam logic [3:0] S_CDIV  = 4'd5;
   localparam logic [3:0] S_OPCHK = 4'd6;
   localparam logic [3:0] S_RDB   = 4'd7;
   localparam logic [3:0] S_RDA   = 4'd8;
   localparam logic [3:0] S_EXEC  = 4'd9;
   localparam logic [3:0] S_ODIV  = 4'd10;
   localparam logic [3:0] S_OMUL  = 4'd11;
   localparam logic [3:0] S_WB    = 4'd12;
   localparam logic [3:0] S_END   = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;
   localparam logic [3:0] S_EMIT  = 4'd15;

   localparam logic [1:0] P_PRE  = 2'd0;
   localparam logic [1:0] P_MAIN = 2'd1;
   localparam logic [1:0] P_END  = 2'd2;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;
   logic [7:0]       op_ff, op_in;
   logic             do_op_ff, do_op_in;
   logic             pending_ff, pending_in;
   logic [63:0]      tok_value_ff, tok_value_in;
   logic [3:0]       tok_fd_ff, tok_fd_in;
   logic             tok_point_ff, tok_point_in;
   logic             tok_open_ff, tok_open_in;
   logic             tok_stop_ff, tok_stop_in;
   logic             tok_neg_ff, tok_neg_in;
   logic [2:0]       err_ff, err_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [63:0]       mem_wdata, mem_rdata;
   logic              div_start, div_neg, div_done;
   logic [63:0]       div_num, div_den, div_value;
   logic              mul_start, mul_done;
   logic [63:0]       mul_value;

   logic        is_digit, fits;
   logic [3:0]  digit;
   logic [63:0] sum, diff;
   logic [CNT_W-1:0] cnt_m1, cnt_m2;

   rpn_stack u_stack (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   rpn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .neg   (div_neg),
      .done  (div_done),
      .value (div_value)
   );

   rpn_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (a_ff),
      .b     (b_ff),
      .done  (mul_done),
      .value (mul_value)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      op_in        = op_ff;
      do_op_in     = do_op_ff;
      pending_in   = pending_ff;
      tok_value_in = tok_value_ff;
      tok_fd_in    = tok_fd_ff;
      tok_point_in = tok_point_ff;
      tok_open_in  = tok_open_ff;
      tok_stop_in  = tok_stop_ff;
      tok_neg_in   = tok_neg_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      div_neg      = 1'b0;
      mul_start    = 1'b0;

      is_digit = (char_ff >= CH_DIGIT_LO) && (char_ff <= CH_DIGIT_HI);
      digit    = 4'(char_ff - CH_DIGIT_LO);
      fits     = (tok_value_ff < FIT_LIMIT) || ((tok_value_ff == FIT_LIMIT) && (digit <= 4'd5));
      sum      = a_ff + b_ff;
      diff     = a_ff - b_ff;
      cnt_m1   = cnt_ff - 1'b1;
      cnt_m2   = cnt_ff - 2'd2;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               char_in  = req_data.char_code;
               last_in  = req_data.end_of_expression;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            phase_in = P_PRE;
            state_in = S_MAIN;
            if (pending_ff) begin
               pending_in = 1'b0;
               if (is_digit || char_ff == CH_POINT) begin
                  tok_open_in = 1'b1;
                  tok_neg_in  = 1'b1;
               end else begin
                  op_in    = CH_MINUS;
                  do_op_in = 1'b1;
                  state_in = S_CLOSE;
               end
            end
         end
         S_MAIN: begin
            phase_in = P_MAIN;
            case (char_ff)
               CH_MINUS: begin
                  pending_in = 1'b1;
                  do_op_in   = 1'b0;
                  state_in   = S_CLOSE;
               end
               CH_PLUS, CH_STAR, CH_SLASH: begin
                  op_in    = char_ff;
                  do_op_in = 1'b1;
                  state_in = S_CLOSE;
               end
               CH_SPACE: begin
                  do_op_in = 1'b0;
                  state_in = S_CLOSE;
               end
               default: begin
                  tok_open_in = 1'b1;
                  state_in    = S_NEXT;
                  if (!tok_stop_ff) begin
                     if (is_digit) begin
                        if (!tok_point_ff) begin
                           tok_value_in = fits ? ((tok_value_ff << 3) + (tok_value_ff << 1)
                                          + 64'(digit)) : '1;
                        end else if (fits && tok_fd_ff < 4'(MAX_FRAC_DIGITS)) begin
                           tok_value_in = (tok_value_ff << 3) + (tok_value_ff << 1) + 64'(digit);
                           tok_fd_in    = tok_fd_ff + 1'b1;
                        end
                     end else if (char_ff == CH_POINT && !tok_point_ff) begin
                        tok_point_in = 1'b1;
                     end else begin
                        tok_stop_in = 1'b1;
                     end
                  end
               end
            endcase
         end
         S_NEXT: begin
            unique case (phase_ff)
               P_PRE:   state_in = S_MAIN;
               P_MAIN:  state_in = last_ff ? S_END : S_IDLE;
               default: state_in = S_FIN;
            endcase
         end
         S_CLOSE: begin
            if (tok_open_ff) begin
               div_start = 1'b1;
               div_num   = tok_value_ff;
               div_den   = pow10(tok_fd_ff);
               div_neg   = tok_neg_ff;
               state_in  = S_CDIV;
            end else begin
               state_in = do_op_ff ? S_OPCHK : S_NEXT;
            end
            if (!tok_open_ff) begin
               tok_value_in = '0;
               tok_fd_in    = '0;
               tok_point_in = 1'b0;
               tok_stop_in  = 1'b0;
               tok_neg_in   = 1'b0;
            end
         end
         S_CDIV: begin
            if (div_done) begin
               if (err_ff == ST_OK) begin
                  if (cnt_ff >= CNT_W'(STACK_DEPTH)) begin
                     err_in = ST_OVER;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = cnt_ff[ADDR_W-1:0];
                     mem_wdata = div_value;
                     cnt_in    = cnt_ff + 1'b1;
                  end
               end
               tok_value_in = '0;
               tok_fd_in    = '0;
               tok_point_in = 1'b0;
               tok_open_in  = 1'b0;
               tok_stop_in  = 1'b0;
               tok_neg_in   = 1'b0;
               state_in     = do_op_ff ? S_OPCHK : S_NEXT;
            end
         end
         S_OPCHK: begin
            if (err_ff != ST_OK) begin
               state_in = S_NEXT;
            end else if (cnt_ff < CNT_W'(2)) begin
               err_in   = ST_UNDER;
               state_in = S_NEXT;
            end else begin
               mem_raddr = cnt_m1[ADDR_W-1:0];
               state_in  = S_RDB;
            end
         end
         S_RDB: begin
            b_in      = mem_rdata;
            mem_raddr = cnt_m2[ADDR_W-1:0];
            state_in  = S_RDA;
         end
         S_RDA: begin
            a_in     = mem_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (op_ff)
               CH_MINUS: begin
                  r_in = diff;
                  if ((a_ff[63] ^ b_ff[63]) && (diff[63] ^ a_ff[63])) begin
                     r_in = a_ff[63] ? SIGN_BIT : MAX_POS;
                  end
                  state_in = S_WB;
               end
               CH_STAR: begin
                  mul_start = 1'b1;
                  state_in  = S_OMUL;
               end
               CH_SLASH: begin
                  if (b_ff == '0) begin
                     err_in   = ST_DIVZ;
                     state_in = S_NEXT;
                  end else begin
                     div_start = 1'b1;
                     div_num   = mag_of(a_ff);
                     div_den   = mag_of(b_ff);
                     div_neg   = a_ff[63] ^ b_ff[63];
                     state_in  = S_ODIV;
                  end
               end
               default: begin
                  r_in = sum;
                  if (!(a_ff[63] ^ b_ff[63]) && (sum[63] ^ a_ff[63])) begin
                     r_in = a_ff[63] ? SIGN_BIT : MAX_POS;
                  end
                  state_in = S_WB;
               end
            endcase
         end
         S_ODIV: begin
            if (div_done) begin
               r_in     = div_value;
               state_in = S_WB;
            end
         end
         S_OMUL: begin
            if (mul_done) begin
               r_in     = mul_value;
               state_in = S_WB;
            end
         end
         S_WB: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m2[ADDR_W-1:0];
            mem_wdata = r_ff;
            cnt_in    = cnt_m1;
            state_in  = S_NEXT;
         end
         S_END: begin
            phase_in   = P_END;
            op_in      = CH_MINUS;
            do_op_in   = pending_ff;
            pending_in = 1'b0;
            state_in   = S_CLOSE;
         end
         S_FIN: begin
            state_in = S_EMIT;
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.result_value = '0;
               if (err_ff != ST_OK) begin
                  rsp_data_in.status = err_ff;
               end else if (cnt_ff == '0) begin
                  rsp_data_in.status = ST_UNDER;
               end else if (cnt_ff > CNT_W'(1)) begin
                  rsp_data_in.status = ST_LEFT;
               end else begin
                  rsp_data_in.status       = ST_OK;
                  rsp_data_in.result_value = mem_rdata;
               end
               cnt_in       = '0;
               err_in       = ST_OK;
               pending_in   = 1'b0;
               tok_value_in = '0;
               tok_fd_in    = '0;
               tok_point_in = 1'b0;
               tok_open_in  = 1'b0;
               tok_stop_in  = 1'b0;
               tok_neg_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_PRE;
         do_op_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         tok_value_ff <= '0;
         tok_fd_ff    <= '0;
         tok_point_ff <= 1'b0;
         tok_open_ff  <= 1'b0;
         tok_stop_ff  <= 1'b0;
         tok_neg_ff   <= 1'b0;
         err_ff       <= ST_OK;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         do_op_ff     <= do_op_in;
         pending_ff   <= pending_in;
         tok_value_ff <= tok_value_in;
         tok_fd_ff    <= tok_fd_in;
         tok_point_ff <= tok_point_in;
         tok_open_ff  <= tok_open_in;
         tok_stop_ff  <= tok_stop_in;
         tok_neg_ff   <= tok_neg_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff     <= char_in;
      last_ff     <= last_in;
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && state_in == S_IDLE) |=> (cnt_ff == '0 && err_ff == ST_OK))
      else $error("state not cleared after result");

   a_err_sticks: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && state_ff != S_EMIT) |=> (err_ff == $past(err_ff)))
      else $error("error code changed before end of expression");

   a_wb_has_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> (cnt_ff >= CNT_W'(2)))
      else $error("write back with fewer than two values");

endmodule
`default_nettype wire

FILE: dv/rpn_expression_evaluator_tb.sv
// rpn_expression_evaluator_tb: drives rpn expressions one character per word and
// checks every result word against a bit-accurate evaluator kept in the bench
// depends on rpn_pkg and rpn_expression_evaluator
`timescale 1ns / 100ps
`default_nettype none
module rpn_expression_evaluator_tb;
   import rpn_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rpn_expression_evaluator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // evaluator state
   logic [63:0]      ev_stack [STACK_DEPTH];
   int unsigned      ev_count;
   logic [63:0]      tok_digits;
   int unsigned      tok_frac;
   bit               tok_point, tok_open, tok_stopped, tok_neg, minus_held;
   logic [2:0]       ev_err;

   rsp_type          expected_results [$];
   int               failures = 0;
   int               results_seen = 0;
   int               sent_chars = 0;
   int               exprs_sent = 0;
   int               status_hits [5];

   function automatic logic [63:0] sat_signed(bit neg, logic [63:0] mag);
      logic [63:0] lim;
      lim = neg ? SIGN_BIT : MAX_POS;
      if (mag > lim) mag = lim;
      return neg ? (64'd0 - mag) : mag;
   endfunction

   function automatic logic [63:0] abs64(logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [63:0] fixed_quotient(logic [63:0] num, logic [63:0] den,
                                                  logic [63:0] lim);
      logic [63:0] q, r, frac;
      q = num / den;
      r = num % den;
      frac = '0;
      if (q > (lim >> FRAC_BITS)) return lim;
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= den) begin
            r = r - den;
            frac[0] = 1'b1;
         end
      end
      q = (q << FRAC_BITS) | frac;
      return (q > lim) ? lim : q;
   endfunction

   function automatic logic [63:0] fixed_product(logic [63:0] a, logic [63:0] b);
      bit           neg;
      logic [127:0] p;
      neg = a[63] ^ b[63];
      p = abs64(a) * abs64(b);
      if (p[127:64+FRAC_BITS] != 0) return neg ? SIGN_BIT : MAX_POS;
      return sat_signed(neg, p[64+FRAC_BITS-1:FRAC_BITS]);
   endfunction

   function automatic void clear_evaluator();
      ev_count = 0;
      tok_digits = '0;
      tok_frac = 0;
      tok_point = 0;
      tok_open = 0;
      tok_stopped = 0;
      tok_neg = 0;
      minus_held = 0;
      ev_err = ST_OK;
   endfunction

   function automatic void push_number(logic [63:0] v);
      if (ev_err != ST_OK) return;
      if (ev_count >= STACK_DEPTH) begin
         ev_err = ST_OVER;
         return;
      end
      ev_stack[ev_count] = v;
      ev_count++;
   endfunction

   function automatic void close_number();
      logic [63:0] lim;
      if (tok_open) begin
         lim = tok_neg ? SIGN_BIT : MAX_POS;
         push_number(sat_signed(tok_neg, fixed_quotient(tok_digits, pow10(4'(tok_frac)),
                                                        lim)));
      end
      tok_digits = '0;
      tok_frac = 0;
      tok_point = 0;
      tok_open = 0;
      tok_stopped = 0;
      tok_neg = 0;
   endfunction

   function automatic void apply_operator(logic [7:0] op);
      logic [63:0] a, b, r;
      bit          neg;
      close_number();
      if (ev_err != ST_OK) return;
      if (ev_count < 2) begin
         ev_err = ST_UNDER;
         return;
      end
      b = ev_stack[ev_count-1];
      a = ev_stack[ev_count-2];
      case (op)
         CH_PLUS: begin
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? SIGN_BIT : MAX_POS;
         end
         CH_MINUS: begin
            r = a - b;
            if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? SIGN_BIT : MAX_POS;
         end
         CH_STAR: r = fixed_product(a, b);
         default: begin
            neg = a[63] ^ b[63];
            if (b == 0) begin
               ev_err = ST_DIVZ;
               return;
            end
            r = sat_signed(neg, fixed_quotient(abs64(a), abs64(b),
                                               neg ? SIGN_BIT : MAX_POS));
         end
      endcase
      ev_count--;
      ev_stack[ev_count-1] = r;
   endfunction

   // returns 1 with the result when the character ends the expression
   function automatic bit evaluate_char(req_type w, output rsp_type res);
      logic [7:0]  c;
      logic [63:0] d;
      bit          is_digit, fits;
      c = w.char_code;
      is_digit = (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI);
      res = '0;
      if (minus_held) begin
         minus_held = 0;
         if (is_digit || c == CH_POINT) begin
            tok_open = 1;
            tok_neg = 1;
         end else begin
            apply_operator(CH_MINUS);
         end
      end
      if (c == CH_MINUS) begin
         close_number();
         minus_held = 1;
      end else if (c == CH_PLUS || c == CH_STAR || c == CH_SLASH) begin
         apply_operator(c);
      end else if (c == CH_SPACE) begin
         close_number();
      end else begin
         tok_open = 1;
         if (!tok_stopped) begin
            if (is_digit) begin
               d = 64'(c - CH_DIGIT_LO);
               fits = tok_digits <= (64'hFFFF_FFFF_FFFF_FFFF - d) / 10;
               if (!tok_point)
                  tok_digits = fits ? tok_digits * 10 + d : 64'hFFFF_FFFF_FFFF_FFFF;
               else if (fits && tok_frac < MAX_FRAC_DIGITS) begin
                  tok_digits = tok_digits * 10 + d;
                  tok_frac++;
               end
            end else if (c == CH_POINT && !tok_point) begin
               tok_point = 1;
            end else begin
               tok_stopped = 1;
            end
         end
      end
      if (!w.end_of_expression) return 0;
      if (minus_held) begin
         minus_held = 0;
         apply_operator(CH_MINUS);
      end
      close_number();
      res.status = ev_err;
      res.result_value = '0;
      if (ev_err == ST_OK) begin
         if (ev_count == 0) res.status = ST_UNDER;
         else if (ev_count > 1) res.status = ST_LEFT;
         else res.result_value = ev_stack[0];
      end
      clear_evaluator();
      return 1;
   endfunction

   task automatic send_char(logic [7:0] c, bit last);
      int      gap;
      rsp_type res;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{char_code: c, end_of_expression: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (evaluate_char('{char_code: c, end_of_expression: last}, res))
         expected_results.push_back(res);
      sent_chars++;
      if (last) exprs_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // directed rows; a row with check_fixed set also compares a typed-in result
   typedef struct {
      string      text;
      bit         check_fixed;
      logic [2:0] status;
      logic [63:0] value;
   } directed_row;

   directed_row directed_rows [] = '{
      '{"1", 1, ST_OK, 64'h0000_0001_0000_0000},
      '{" ", 1, ST_UNDER, 64'd0},
      '{"-1.5", 1, ST_OK, 64'hFFFF_FFFE_8000_0000},
      '{"+", 1, ST_UNDER, 64'd0},
      '{"1 2", 1, ST_LEFT, 64'd0},
      '{"1 0/", 1, ST_DIVZ, 64'd0},
      '{"1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8", 1, ST_OVER, 64'd0},
      '{"99999999999999999999999", 1, ST_OK, MAX_POS},
      '{"-99999999999999999999999", 1, ST_OK, SIGN_BIT},
      '{"3 4-", 0, 0, 0},
      '{"3 4 -", 0, 0, 0},
      '{"3 -4*", 0, 0, 0},
      '{"1 3/", 0, 0, 0},
      '{"-7 2/", 0, 0, 0},
      '{"0.1234567890123", 0, 0, 0},
      '{".", 0, 0, 0},
      '{"-", 0, 0, 0},
      '{"-.", 0, 0, 0},
      '{"12a34 1+", 0, 0, 0},
      '{"1.2.3", 0, 0, 0},
      '{"2000000000 2000000000*", 0, 0, 0},
      '{"2000000000 2000000000+2000000000+2000000000+2000000000+", 0, 0, 0},
      '{"-2000000000 2000000000 -", 0, 0, 0},
      '{"1 0.0000000001/", 0, 0, 0},
      '{"5 1 2+*-", 0, 0, 0}
   };

   function automatic logic [7:0] random_char();
      int k;
      k = $urandom_range(0, 19);
      if (k < 9) return CH_DIGIT_LO + 8'($urandom_range(0, 9));
      if (k < 11) return CH_SPACE;
      if (k == 11) return CH_POINT;
      if (k == 12) return CH_PLUS;
      if (k == 13) return CH_MINUS;
      if (k == 14) return CH_STAR;
      if (k == 15) return CH_SLASH;
      return 8'($urandom_range(0, 255));
   endfunction

   // a well-formed expression with random numbers, mostly shallow
   task automatic send_wellformed();
      int    depth, nums;
      string s, ops;
      ops = "+-*/";
      nums = $urandom_range(1, 5);
      depth = 0;
      s = "";
      for (int n = 0; n < nums; n++) begin
         if ($urandom_range(0, 3) == 0) s = {s, "-"};
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 14 : 4))
            s = {s, string'(8'(CH_DIGIT_LO + $urandom_range(0, 9)))};
         if ($urandom_range(0, 2) == 0) begin
            s = {s, "."};
            repeat ($urandom_range(0, 11))
               s = {s, string'(8'(CH_DIGIT_LO + $urandom_range(0, 9)))};
         end
         depth++;
         s = {s, " "};
         while (depth > 1 && $urandom_range(0, 1)) begin
            s = {s, string'(ops[$urandom_range(0, 3)])};
            depth--;
         end
      end
      while (depth > 1) begin
         s = {s, string'(ops[$urandom_range(0, 3)])};
         depth--;
      end
      send_text(s);
   endtask

   task automatic send_noise();
      int len;
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) send_char(random_char(), i == len - 1);
   endtask

   // response side
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected: value %h status %0d",
                   rsp_data.result_value, rsp_data.status);
            failures++;
         end else begin
            want = expected_results.pop_front();
            status_hits[want.status]++;
            if (want.status !== rsp_data.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_data.status);
               failures++;
            end
            if (want.result_value !== rsp_data.result_value) begin
               $error("result_value: expected %h actual %h",
                      want.result_value, rsp_data.result_value);
               failures++;
            end
         end
      end
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 16);
            rsp_stall <= (hold > 0);
            continue;
         end
         rsp_stall <= (hold > 0);
      end
   end

   initial begin
      rsp_type typed;
      clear_evaluator();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].check_fixed) begin
            typed.status = directed_rows[i].status;
            typed.result_value = directed_rows[i].value;
         end
         send_text(directed_rows[i].text);
         if (directed_rows[i].check_fixed &&
             expected_results[$] !== typed) begin
            $error("directed row %s: evaluator disagrees with typed result",
                   directed_rows[i].text);
            failures++;
         end
      end
      while (sent_chars < 1750) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else send_wellformed();
      end
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("covered %0d expressions in %0d characters, %0d result words", exprs_sent,
               sent_chars, results_seen);
      $display("status mix ok %0d under %0d left %0d over %0d divz %0d", status_hits[0],
               status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
      if (failures == 0)
         $display("rpn_expression_evaluator_tb OK");
      else
         $display("rpn_expression_evaluator_tb NOT OK");
      $finish;
   end

   initial begin
      #60ms;
      $display("rpn_expression_evaluator_tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
src/rpn_pkg.sv
src/rpn_stack.sv
src/rpn_div.sv
src/rpn_mul.sv
src/rpn_expression_evaluator.sv
dv/rpn_expression_evaluator_tb.sv
